FILE: rtl/positional_list_store_core_macros.svh
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// Checks a property that must hold at every clock edge out of reset.
`define PLSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/plsc_pkg.sv
// Package for the positional list store: sizes, codes and the microcode ROM.
package plsc_pkg;

  localparam int Capacity = 32;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int PosW     = 6;
  localparam int ValW     = 32;
  localparam int CmpW     = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int StepW    = 5;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_COUNT  = 3'd3,
    OP_PRINT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_ERROR = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_BLANK = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_INS_BAD,
    C_POS_GE_CNT,
    C_IDX_LE_POS,
    C_IDX1_GE_CNT,
    C_IDX1_LT_CNT,
    C_CNT_ZERO
  } cond_e;

  typedef enum logic [2:0] {
    I_HOLD,
    I_CNT,
    I_POS,
    I_ZERO,
    I_DEC,
    I_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_P1,
    RA_POS
  } ra_sel_e;

  typedef enum logic [1:0] {
    K_HOLD,
    K_INC,
    K_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    EV_ZERO,
    EV_RDATA,
    EV_CNT
  } ev_sel_e;

  // One microcode control word.
  typedef struct packed {
    cond_e              cond;
    logic [StepW-1:0]   target;
    logic               fin;
    idx_op_e            idx_op;
    logic               rd_en;
    ra_sel_e            ra_sel;
    logic               wr_en;
    logic               wa_pos;     // write address: position instead of index
    logic               wd_val;     // write data: input value instead of read data
    cnt_op_e            cnt_op;
    logic               emit_en;
    kind_e              kind;
    ev_sel_e            ev_sel;
    logic               last_cmp;   // last mark from index compare instead of one
  } cw_t;

  // Program addresses.
  localparam logic [StepW-1:0] S_INS       = 5'd0;
  localparam logic [StepW-1:0] S_INS_TEST  = 5'd1;
  localparam logic [StepW-1:0] S_INS_MOVE  = 5'd2;
  localparam logic [StepW-1:0] S_INS_WR    = 5'd3;
  localparam logic [StepW-1:0] S_REM       = 5'd4;
  localparam logic [StepW-1:0] S_REM_TEST  = 5'd5;
  localparam logic [StepW-1:0] S_REM_MOVE  = 5'd6;
  localparam logic [StepW-1:0] S_REM_END   = 5'd7;
  localparam logic [StepW-1:0] S_GET       = 5'd8;
  localparam logic [StepW-1:0] S_GET_EMIT  = 5'd9;
  localparam logic [StepW-1:0] S_CNT       = 5'd10;
  localparam logic [StepW-1:0] S_PRT       = 5'd11;
  localparam logic [StepW-1:0] S_PRT_RD    = 5'd12;
  localparam logic [StepW-1:0] S_PRT_EMIT  = 5'd13;
  localparam logic [StepW-1:0] S_BLANK     = 5'd14;
  localparam logic [StepW-1:0] S_ERR       = 5'd15;
  localparam logic [StepW-1:0] S_NOP       = 5'd16;
  localparam logic [StepW-1:0] S_LAST      = S_NOP;

  localparam cw_t CW_NOP = '{
    cond: C_NEVER, target: S_NOP, fin: 1'b0, idx_op: I_HOLD, rd_en: 1'b0,
    ra_sel: RA_IDX, wr_en: 1'b0, wa_pos: 1'b0, wd_val: 1'b0, cnt_op: K_HOLD,
    emit_en: 1'b0, kind: KIND_ERROR, ev_sel: EV_ZERO, last_cmp: 1'b0
  };

  function automatic logic [StepW-1:0] plsc_dispatch(input logic [2:0] op);
    logic [StepW-1:0] step;
    unique case (op)
      OP_INSERT: step = S_INS;
      OP_REMOVE: step = S_REM;
      OP_GET:    step = S_GET;
      OP_COUNT:  step = S_CNT;
      OP_PRINT:  step = S_PRT;
      default:   step = S_NOP;
    endcase
    return step;
  endfunction

  function automatic cw_t plsc_rom(input logic [StepW-1:0] step);
    cw_t cw;
    cw = CW_NOP;
    unique case (step)
      S_INS: begin
        cw.cond = C_INS_BAD;     cw.target = S_ERR; cw.idx_op = I_CNT;
      end
      S_INS_TEST: begin
        cw.cond = C_IDX_LE_POS;  cw.target = S_INS_WR;
        cw.rd_en = 1'b1;         cw.ra_sel = RA_IDX_M1;
      end
      S_INS_MOVE: begin
        cw.cond = C_ALWAYS;      cw.target = S_INS_TEST;
        cw.wr_en = 1'b1;         cw.idx_op = I_DEC;
      end
      S_INS_WR: begin
        cw.wr_en = 1'b1;  cw.wa_pos = 1'b1;  cw.wd_val = 1'b1;
        cw.cnt_op = K_INC; cw.fin = 1'b1;
      end
      S_REM: begin
        cw.cond = C_POS_GE_CNT;  cw.target = S_ERR; cw.idx_op = I_POS;
      end
      S_REM_TEST: begin
        cw.cond = C_IDX1_GE_CNT; cw.target = S_REM_END;
        cw.rd_en = 1'b1;         cw.ra_sel = RA_IDX_P1;
      end
      S_REM_MOVE: begin
        cw.cond = C_ALWAYS;      cw.target = S_REM_TEST;
        cw.wr_en = 1'b1;         cw.idx_op = I_INC;
      end
      S_REM_END: begin
        cw.cnt_op = K_DEC; cw.fin = 1'b1;
      end
      S_GET: begin
        cw.cond = C_POS_GE_CNT;  cw.target = S_ERR;
        cw.rd_en = 1'b1;         cw.ra_sel = RA_POS;
      end
      S_GET_EMIT: begin
        cw.emit_en = 1'b1; cw.kind = KIND_VALUE; cw.ev_sel = EV_RDATA; cw.fin = 1'b1;
      end
      S_CNT: begin
        cw.emit_en = 1'b1; cw.kind = KIND_COUNT; cw.ev_sel = EV_CNT; cw.fin = 1'b1;
      end
      S_PRT: begin
        cw.cond = C_CNT_ZERO;    cw.target = S_BLANK; cw.idx_op = I_ZERO;
      end
      S_PRT_RD: begin
        cw.rd_en = 1'b1;         cw.ra_sel = RA_IDX;
      end
      S_PRT_EMIT: begin
        cw.cond = C_IDX1_LT_CNT; cw.target = S_PRT_RD; cw.idx_op = I_INC;
        cw.emit_en = 1'b1; cw.kind = KIND_VALUE; cw.ev_sel = EV_RDATA;
        cw.last_cmp = 1'b1; cw.fin = 1'b1;
      end
      S_BLANK: begin
        cw.emit_en = 1'b1; cw.kind = KIND_BLANK; cw.fin = 1'b1;
      end
      S_ERR: begin
        cw.emit_en = 1'b1; cw.kind = KIND_ERROR; cw.fin = 1'b1;
      end
      default: begin
        cw.fin = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/positional_list_store_core.sv
// Positional list store: microcoded sequencer over a single-port list memory.
// Count emits first; get, blank and error emit after a check; print reads, emits each entry.
// Insert and remove check, then test and move each shifted entry; each shift step reads the one
// memory port (registered read) and then writes the entry back one place over.
// One item is worked at a time; the next is taken once the last step has issued.
// Reset clears the count and sequencer; list memory contents stay undefined.
module positional_list_store_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        opcode_i,
  input  logic [plsc_pkg::PosW-1:0]         position_i,
  input  logic signed [plsc_pkg::ValW-1:0]  item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        result_kind_o,
  output logic signed [plsc_pkg::ValW-1:0]  result_value_o,
  output logic                              last_of_run_o
);
  import plsc_pkg::*;

  `include "positional_list_store_core_macros.svh"

  logic               busy_q, busy_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [PosW-1:0]    pos_q;
  logic [ValW-1:0]    val_q;
  logic [ValW-1:0]    rdata_q;
  logic [ValW-1:0]    mem_q [Capacity];

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_kind_q;
  logic [ValW-1:0]    out_value_q;
  logic               out_last_q;

  cw_t                cw;
  logic               accept;
  logic               hold;
  logic               adv;
  logic               take;
  logic               mem_rd;
  logic               mem_wr;
  logic [IdxW-1:0]    raddr;
  logic [IdxW-1:0]    waddr;
  logic [ValW-1:0]    wdata;
  logic [CmpW-1:0]    idx_x, idx1_x, pos_x, cnt_x;
  logic               out_load;
  logic [ValW-1:0]    emit_value;
  logic               emit_last;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  assign cw   = plsc_rom(step_q);
  assign hold = cw.emit_en && out_valid_q && out_stall_i;
  assign adv  = busy_q && !hold;

  assign idx_x  = CmpW'(idx_q);
  assign idx1_x = idx_x + CmpW'(1);
  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(count_q);

  always_comb begin
    case (cw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_INS_BAD:     take = (pos_x > cnt_x) || (cnt_x >= CmpW'(Capacity));
      C_POS_GE_CNT:  take = pos_x >= cnt_x;
      C_IDX_LE_POS:  take = idx_x <= pos_x;
      C_IDX1_GE_CNT: take = idx1_x >= cnt_x;
      C_IDX1_LT_CNT: take = idx1_x < cnt_x;
      C_CNT_ZERO:    take = count_q == '0;
      default:       take = 1'b0;
    endcase
  end

  // Sequencer: dispatch an accepted item; else, unless held, jump when the condition holds, else finish or step on.
  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (accept) begin
      step_d = plsc_dispatch(opcode_i);
      busy_d = 1'b1;
    end else if (adv) begin
      if (take) begin
        step_d = cw.target;
      end else if (cw.fin) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_comb begin
    idx_d   = idx_q;
    count_d = count_q;
    if (adv) begin
      case (cw.idx_op)
        I_CNT:   idx_d = count_q;
        I_POS:   idx_d = CntW'(pos_q);
        I_ZERO:  idx_d = '0;
        I_DEC:   idx_d = idx_q - CntW'(1);
        I_INC:   idx_d = idx_q + CntW'(1);
        default: idx_d = idx_q;
      endcase
      case (cw.cnt_op)
        K_INC:   count_d = count_q + CntW'(1);
        K_DEC:   count_d = count_q - CntW'(1);
        default: count_d = count_q;
      endcase
    end
  end

  always_comb begin
    case (cw.ra_sel)
      RA_IDX_M1: raddr = idx_q[IdxW-1:0] - IdxW'(1);
      RA_IDX_P1: raddr = idx_q[IdxW-1:0] + IdxW'(1);
      RA_POS:    raddr = pos_q[IdxW-1:0];
      default:   raddr = idx_q[IdxW-1:0];
    endcase
  end

  assign mem_rd = adv && cw.rd_en;
  assign mem_wr = adv && cw.wr_en;
  assign waddr  = cw.wa_pos ? pos_q[IdxW-1:0] : idx_q[IdxW-1:0];
  assign wdata  = cw.wd_val ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    case (cw.ev_sel)
      EV_RDATA: emit_value = rdata_q;
      EV_CNT:   emit_value = ValW'(count_q);
      default:  emit_value = '0;
    endcase
  end

  assign emit_last   = cw.last_cmp ? (idx1_x == cnt_x) : 1'b1;
  assign out_load    = adv && cw.emit_en;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= S_NOP;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    if (out_load) begin
      out_kind_q  <= cw.kind;
      out_value_q <= emit_value;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign result_value_o = $signed(out_value_q);
  assign last_of_run_o  = out_last_q;

  `PLSC_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(Capacity), "list count above capacity")
  `PLSC_ASSERT_NEXT(a_count_idle, !busy_q, $stable(count_q), "count changed while idle")
  `PLSC_ASSERT_NEXT(a_accept_busy, accept, busy_q, "accepted item did not start the sequencer")
  `PLSC_ASSERT_ALWAYS(a_step_range, !busy_q || step_q <= S_LAST, "step counter outside program")
  `PLSC_ASSERT_ALWAYS(a_emit_busy, !out_load || busy_q, "result loaded while idle")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the positional list store core.
module tb_top;
  import plsc_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 100;
  localparam int ReportLimit = 100;

  // Opcodes that the block must ignore.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef enum logic [1:0] {
    ENTRY_CMD,
    ENTRY_PHASE,
    ENTRY_END
  } entry_kind_e;

  typedef struct {
    entry_kind_e            tag;
    logic [2:0]             opcode;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value;
    int                     send_idle_pct;
    int                     recv_stall_pct;
  } list_cmd_t;

  typedef struct {
    kind_e                  kind;
    logic signed [ValW-1:0] value;
    logic                   last;
  } list_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [2:0]             opcode_i = '0;
  logic [PosW-1:0]        position_i = '0;
  logic signed [ValW-1:0] item_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             result_kind_o;
  logic signed [ValW-1:0] result_value_o;
  logic                   last_of_run_o;

  list_cmd_t    cmd_queue[$];
  list_result_t results_due[$];

  // Predicted list contents.
  logic signed [ValW-1:0] list_mem [Capacity];
  int                     list_len = 0;

  // Length the stimulus generator expects, used to aim positions and steer growth.
  int   gen_len = 0;
  logic gen_grow = 1'b1;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic in_taken = 1'b0;
  logic stim_done = 1'b0;
  int   cycle_count = 0;
  int   error_count = 0;

  positional_list_store_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .result_value_o (result_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endtask

  task automatic push_result(input kind_e kind, input logic signed [ValW-1:0] value,
                             input logic last);
    list_result_t res;
    res.kind  = kind;
    res.value = value;
    res.last  = last;
    results_due.push_back(res);
  endtask

  // Applies one command to the predicted list and queues the results it causes.
  task automatic apply_list_cmd(input logic [2:0] op, input logic [PosW-1:0] pos,
                                input logic signed [ValW-1:0] val);
    int i;
    case (op)
      OP_INSERT: begin
        if (pos > list_len || list_len >= Capacity) begin
          push_result(KIND_ERROR, '0, 1'b1);
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (pos >= list_len) begin
          push_result(KIND_ERROR, '0, 1'b1);
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      OP_GET: begin
        if (pos >= list_len) push_result(KIND_ERROR, '0, 1'b1);
        else push_result(KIND_VALUE, list_mem[pos], 1'b1);
      end
      OP_COUNT: begin
        push_result(KIND_COUNT, list_len, 1'b1);
      end
      OP_PRINT: begin
        if (list_len == 0) begin
          push_result(KIND_BLANK, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) push_result(KIND_VALUE, list_mem[i], i + 1 == list_len);
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [PosW-1:0] pos,
                         input logic signed [ValW-1:0] val);
    list_cmd_t cmd;
    cmd.tag      = ENTRY_CMD;
    cmd.opcode   = op;
    cmd.position = pos;
    cmd.value    = val;
    cmd.send_idle_pct  = 0;
    cmd.recv_stall_pct = 0;
    cmd_queue.push_back(cmd);
    if (op == OP_INSERT && pos <= gen_len && gen_len < Capacity) gen_len++;
    else if (op == OP_REMOVE && pos < gen_len) gen_len--;
  endtask

  // A phase marker holds the sender until every queued result has arrived.
  task automatic add_marker(input entry_kind_e tag, input int send_pct, input int stall_pct);
    list_cmd_t cmd;
    cmd.tag      = tag;
    cmd.opcode   = OP_COUNT;
    cmd.position = '0;
    cmd.value    = '0;
    cmd.send_idle_pct  = send_pct;
    cmd.recv_stall_pct = stall_pct;
    cmd_queue.push_back(cmd);
  endtask

  function automatic logic signed [ValW-1:0] random_value();
    logic signed [ValW-1:0] val;
    val = $urandom;
    if ($urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 3))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7FFF_FFFF;
        2: val = '0;
        default: val = '1;
      endcase
    end
    return val;
  endfunction

  // Mostly well-formed commands that sweep the list from empty to full and back.
  task automatic add_random_cmds(input int n_cmds);
    int              made;
    int              r;
    int              ins_lim;
    logic [2:0]      op;
    logic [PosW-1:0] pos;
    made = 0;
    while (made < n_cmds) begin
      if (gen_len == Capacity && gen_grow) begin
        add_cmd(OP_INSERT, PosW'($urandom_range(0, 63)), random_value());
        add_cmd(OP_PRINT, PosW'($urandom_range(0, 63)), random_value());
        add_cmd(OP_COUNT, PosW'($urandom_range(0, 63)), random_value());
        gen_grow = 1'b0;
        made += 3;
      end else begin
        if (gen_len == 0) gen_grow = 1'b1;
        else if ($urandom_range(0, 99) < 2) gen_grow = !gen_grow;
        r = $urandom_range(0, 99);
        ins_lim = gen_grow ? 48 : 18;
        if (r < 3) op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
        else if (r < ins_lim) op = OP_INSERT;
        else if (r < 63) op = OP_REMOVE;
        else if (r < 83) op = OP_GET;
        else if (r < 92) op = OP_COUNT;
        else op = OP_PRINT;
        if ($urandom_range(0, 99) < 12 || op > OP_GET) pos = PosW'($urandom_range(0, 63));
        else if (op == OP_INSERT) pos = PosW'($urandom_range(0, gen_len));
        else if (gen_len > 0) pos = PosW'($urandom_range(0, gen_len - 1));
        else pos = PosW'($urandom_range(0, 63));
        add_cmd(op, pos, random_value());
        if (op <= OP_PRINT) made++;
      end
    end
  endtask

  // Driver: inputs change at the falling edge.
  always @(negedge clk_i) begin : drive_proc
    list_cmd_t nxt;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!in_valid_i || in_taken) begin
        while (cmd_queue.size() != 0 && cmd_queue[0].tag != ENTRY_CMD &&
               results_due.size() == 0) begin
          if (cmd_queue[0].tag == ENTRY_END) begin
            stim_done = 1'b1;
          end else begin
            send_idle_pct  = cmd_queue[0].send_idle_pct;
            recv_stall_pct = cmd_queue[0].recv_stall_pct;
          end
          void'(cmd_queue.pop_front());
        end
        if (cmd_queue.size() != 0 && cmd_queue[0].tag == ENTRY_CMD &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_queue.pop_front();
          opcode_i     <= nxt.opcode;
          position_i   <= nxt.position;
          item_value_i <= nxt.value;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk_i) begin : check_proc
    list_result_t res;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      cycle_count++;
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) apply_list_cmd(opcode_i, position_i, item_value_i);
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          report_error($sformatf("unexpected result kind %0d value %0d",
                                 result_kind_o, result_value_o));
        end else begin
          res = results_due.pop_front();
          if (result_kind_o !== res.kind)
            report_error($sformatf("kind %0d, predicted %0d", result_kind_o, res.kind));
          if (result_value_o !== res.value)
            report_error($sformatf("value %0d, predicted %0d", result_value_o, res.value));
          if (last_of_run_o !== res.last)
            report_error($sformatf("last mark %0b, predicted %0b", last_of_run_o, res.last));
        end
      end
    end
  end

  initial begin
    // Directed part: empty list corners, all three insert spots, bounds and ignored opcodes.
    add_marker(ENTRY_PHASE, 0, 0);
    add_cmd(OP_PRINT,  0,  '0);
    add_cmd(OP_COUNT,  0,  '0);
    add_cmd(OP_GET,    0,  '0);
    add_cmd(OP_REMOVE, 0,  '0);
    add_cmd(OP_INSERT, 1,  32'sd9);
    add_cmd(OP_INSERT, 0,  32'sh7FFF_FFFF);
    add_cmd(OP_INSERT, 0,  32'sh8000_0000);
    add_cmd(OP_INSERT, 2,  -32'sd1);
    add_cmd(OP_INSERT, 1,  '0);
    add_cmd(OP_INSERT, 63, 32'sd5);
    add_cmd(OP_GET,    0,  '0);
    add_cmd(OP_GET,    3,  '0);
    add_cmd(OP_GET,    4,  '0);
    add_cmd(OP_GET,    63, '1);
    add_cmd(OP_PRINT,  0,  '0);
    add_cmd(OP_REMOVE, 1,  '0);
    add_cmd(OP_REMOVE, 2,  '0);
    add_cmd(OP_REMOVE, 63, '0);
    add_cmd(OP_REMOVE, 0,  '0);
    add_cmd(OP_RSVD5,  63, '1);
    add_cmd(OP_RSVD6,  63, '1);
    add_cmd(OP_RSVD7,  63, '1);
    add_cmd(OP_COUNT,  63, '1);
    add_cmd(OP_PRINT,  63, '1);

    add_marker(ENTRY_PHASE, 0, 0);
    add_random_cmds(105);
    add_marker(ENTRY_PHASE, 64, 0);
    add_random_cmds(105);
    add_marker(ENTRY_PHASE, 0, 64);
    add_random_cmds(105);
    add_marker(ENTRY_PHASE, 10, 10);
    add_random_cmds(105);
    add_marker(ENTRY_END, 0, 0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_done);
    repeat (DrainCycles) @(negedge clk_i);
    if (results_due.size() != 0)
      report_error($sformatf("%0d predicted results never arrived", results_due.size()));
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: positional_list_store_core.f
+incdir+rtl
rtl/plsc_pkg.sv
rtl/positional_list_store_core.sv
sim/tb_top.sv
